>>> design/fss_pkg.sv
// shared types and constants for the flywheel speed stepper
package fss_pkg;

  localparam int MODE_W   = 2;
  localparam int RPM_W    = 11;
  localparam int DMS_W    = 8;
  localparam int TARGET_W = 10;
  localparam int POWER_W  = 14;
  localparam int ERR_W    = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_RAISE  = 2'd1,
    MODE_LOWER  = 2'd2,
    MODE_TOGGLE = 2'd3
  } mode_t;

  localparam logic [TARGET_W-1:0] TARGET_RESET       = 10'd480;
  localparam logic [TARGET_W-1:0] TARGET_RAISE_LIMIT = 10'd590;
  localparam logic [TARGET_W-1:0] TARGET_LOWER_LIMIT = 10'd350;
  localparam logic [TARGET_W-1:0] TARGET_STEP        = 10'd5;

  localparam int PWR_CALC_W = POWER_W + 2;
  localparam logic signed [PWR_CALC_W-1:0] POWER_STEP = 16'sd18;
  localparam logic signed [PWR_CALC_W-1:0] POWER_FULL = 16'sd9600;

  // control state that travels between the top level and the update logic
  typedef struct packed {
    logic                running;
    logic [POWER_W-1:0]  power;
    logic [TARGET_W-1:0] target;
  } ctl_t;

  // power preset: target times 16
  function automatic logic [POWER_W-1:0] power_preset(input logic [TARGET_W-1:0] tgt);
    power_preset = {tgt, 4'b0000};
  endfunction

endpackage

>>> design/fss_step.sv
// next-state and result logic for one command beat
module fss_step import fss_pkg::*; #(
  parameter int TIME_BITS = 24
) (
  input  mode_t                       mode,
  input  logic signed [RPM_W-1:0]     rpm,
  input  logic        [DMS_W-1:0]     dms,
  input  ctl_t                        ctl_cur,
  input  logic        [TIME_BITS-1:0] time_cur,
  output ctl_t                        ctl_nxt,
  output logic        [TIME_BITS-1:0] time_nxt,
  output logic signed [ERR_W-1:0]     err
);

  // compare width covers 500*|err| and 20*target + timer
  localparam int CW = ((TIME_BITS > 20) ? TIME_BITS : 20) + 1;

  logic        [TIME_BITS:0]    time_sum;
  logic signed [ERR_W-1:0]      err_calc;
  logic        [ERR_W-1:0]      err_abs;
  logic        [CW-1:0]         mag_w;
  logic        [CW-1:0]         mag50;
  logic        [CW-1:0]         mag500;
  logic        [CW-1:0]         window;
  logic        [CW-1:0]         tgt_w;
  logic                         in_band;
  logic signed [PWR_CALC_W-1:0] pwr_step;

  always_comb begin
    ctl_nxt  = ctl_cur;
    time_nxt = time_cur;
    err      = '0;

    time_sum = {1'b0, time_cur} + (TIME_BITS+1)'(dms);
    err_calc = $signed({2'b00, ctl_cur.target}) - $signed({rpm[RPM_W-1], rpm});
    err_abs  = err_calc[ERR_W-1] ? ERR_W'(-err_calc) : err_calc;
    mag_w    = CW'(err_abs[RPM_W-1:0]);
    tgt_w    = CW'(ctl_cur.target);
    mag50    = mag_w * CW'(50);
    mag500   = mag_w * CW'(500);
    // timer after saturation feeds the window
    window   = tgt_w * CW'(20) +
               (time_sum[TIME_BITS] ? CW'({TIME_BITS{1'b1}}) : CW'(time_sum[TIME_BITS-1:0]));
    in_band  = (mag50 > tgt_w) && (mag500 < window);
    pwr_step = $signed({2'b00, ctl_cur.power});
    if (in_band) begin
      pwr_step = err_calc[ERR_W-1] ? pwr_step - POWER_STEP : pwr_step + POWER_STEP;
    end

    case (mode)
      MODE_RAISE: begin
        if (ctl_cur.target < TARGET_RAISE_LIMIT) begin
          ctl_nxt.target = ctl_cur.target + TARGET_STEP;
          ctl_nxt.power  = power_preset(ctl_cur.target + TARGET_STEP);
        end
      end
      MODE_LOWER: begin
        if (ctl_cur.target > TARGET_LOWER_LIMIT) begin
          ctl_nxt.target = ctl_cur.target - TARGET_STEP;
          ctl_nxt.power  = power_preset(ctl_cur.target - TARGET_STEP);
        end
      end
      MODE_TOGGLE: begin
        if (!ctl_cur.running) begin
          ctl_nxt.running = 1'b1;
          ctl_nxt.power   = power_preset(ctl_cur.target);
        end else begin
          ctl_nxt.running = 1'b0;
        end
      end
      MODE_TICK: begin
        if (!ctl_cur.running) begin
          time_nxt = '0;
        end else begin
          time_nxt = time_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : time_sum[TIME_BITS-1:0];
          err      = err_calc;
          if (pwr_step > POWER_FULL) begin
            ctl_nxt.power = POWER_FULL[POWER_W-1:0];
          end else if (pwr_step < 0) begin
            ctl_nxt.power = '0;
          end else begin
            ctl_nxt.power = pwr_step[POWER_W-1:0];
          end
        end
      end
      default: begin
        ctl_nxt = ctl_cur;
      end
    endcase
  end

endmodule

>>> design/flywheel_speed_stepper.sv
// flywheel speed stepper top level: input register, update logic, result register
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_ready  | in_mode, in_measured_rpm, in_delta_ms
//   out     | out_valid / out_ready| out_running, out_drive_power, out_target_rpm,
//           |                      | out_speed_error
//
// one beat in, one beat out; each beat passes the input register, then the result register,
// and a new beat is taken every cycle while the output side keeps draining.
// the throughput limit is the combinational state update between the two registers.
// reset puts the target at 480 rpm, power and timer at zero, motor off.
// when out_ready is low while a result waits, the result register holds and the input
// register fills, after which in_ready drops.
module flywheel_speed_stepper import fss_pkg::*; #(
  parameter int TIME_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic signed [RPM_W-1:0] in_measured_rpm,
  input  logic [DMS_W-1:0]        in_delta_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_running,
  output logic [POWER_W-1:0]      out_drive_power,
  output logic [TARGET_W-1:0]     out_target_rpm,
  output logic signed [ERR_W-1:0] out_speed_error
);

  logic                    in_vld_r;
  mode_t                   mode_r;
  logic signed [RPM_W-1:0] rpm_r;
  logic [DMS_W-1:0]        dms_r;

  ctl_t                    ctl_r;
  ctl_t                    ctl_nxt;
  logic [TIME_BITS-1:0]    time_r;
  logic [TIME_BITS-1:0]    time_nxt;
  logic signed [ERR_W-1:0] err_nxt;

  logic                    out_vld_r;
  ctl_t                    res_r;
  logic signed [ERR_W-1:0] res_err_r;

  logic                    out_free;
  logic                    stage_go;

  assign out_free = !out_vld_r || out_ready;
  assign stage_go = in_vld_r && out_free;
  assign in_ready = !in_vld_r || stage_go;

  fss_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .mode     (mode_r),
    .rpm      (rpm_r),
    .dms      (dms_r),
    .ctl_cur  (ctl_r),
    .time_cur (time_r),
    .ctl_nxt  (ctl_nxt),
    .time_nxt (time_nxt),
    .err      (err_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      mode_r <= mode_t'(in_mode);
      rpm_r  <= in_measured_rpm;
      dms_r  <= in_delta_ms;
    end
  end

  // regulator state commits when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.running <= 1'b0;
      ctl_r.power   <= '0;
      ctl_r.target  <= TARGET_RESET;
      time_r        <= '0;
    end else if (stage_go) begin
      ctl_r  <= ctl_nxt;
      time_r <= time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
    if (stage_go) begin
      res_r     <= ctl_nxt;
      res_err_r <= err_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_running     = res_r.running;
  assign out_drive_power = res_r.power;
  assign out_target_rpm  = res_r.target;
  assign out_speed_error = res_err_r;

endmodule

>>> tb/tb_flywheel_speed_stepper.sv
// self-checking testbench for the flywheel speed stepper
module tb_flywheel_speed_stepper;
  import fss_pkg::*;

  localparam int TB_TIME_BITS = 16;
  localparam longint TIMER_MAX = (longint'(1) << TB_TIME_BITS) - 1;
  localparam int PWR_PER_RPM = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PLAN_ITEMS = 450;

  typedef struct {
    mode_t             mode;
    logic [RPM_W-1:0]  rpm;
    logic [DMS_W-1:0]  dms;
    bit                drain;
  } fw_cmd_t;

  typedef struct {
    logic                    running;
    logic [POWER_W-1:0]      power;
    logic [TARGET_W-1:0]     target;
    logic signed [ERR_W-1:0] err;
  } fw_result_t;

  typedef struct {
    int     target;
    int     power;
    bit     on;
    longint elapsed;
  } fw_state_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [MODE_W-1:0]       in_mode = MODE_TICK;
  logic signed [RPM_W-1:0] in_measured_rpm = '0;
  logic [DMS_W-1:0]        in_delta_ms = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_running;
  logic [POWER_W-1:0]      out_drive_power;
  logic [TARGET_W-1:0]     out_target_rpm;
  logic signed [ERR_W-1:0] out_speed_error;

  fw_cmd_t    cmd_queue[$];
  fw_result_t expected_results[$];
  fw_state_t  plan_shadow = '{int'(TARGET_RESET), 0, 1'b0, 0};
  fw_state_t  ctl_shadow = '{int'(TARGET_RESET), 0, 1'b0, 0};
  fw_cmd_t    live_cmd;
  bit         next_drain = 1'b0;

  int total_cmds = 0;
  int beats_in = 0;
  int beats_out = 0;
  int mismatches = 0;
  int full_hits = 0;
  int zero_hits = 0;
  int sat_hits = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int pat_left = 0;
  logic [7:0] ready_pat = 8'hFF;
  logic [2:0] pat_pos = '0;

  flywheel_speed_stepper #(.TIME_BITS(TB_TIME_BITS)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_measured_rpm (in_measured_rpm),
    .in_delta_ms     (in_delta_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_running     (out_running),
    .out_drive_power (out_drive_power),
    .out_target_rpm  (out_target_rpm),
    .out_speed_error (out_speed_error)
  );

  always #5 clk = ~clk;

  // advances the regulator state by one command and returns the reported values
  function automatic fw_result_t flywheel_update(inout fw_state_t st, input fw_cmd_t c);
    fw_result_t r;
    int err;
    int mag;
    err = 0;
    case (c.mode)
      MODE_RAISE: begin
        if (st.target < int'(TARGET_RAISE_LIMIT)) begin
          st.target += int'(TARGET_STEP);
          st.power = st.target * PWR_PER_RPM;
        end
      end
      MODE_LOWER: begin
        if (st.target > int'(TARGET_LOWER_LIMIT)) begin
          st.target -= int'(TARGET_STEP);
          st.power = st.target * PWR_PER_RPM;
        end
      end
      MODE_TOGGLE: begin
        if (!st.on) begin
          st.power = st.target * PWR_PER_RPM;
          st.on = 1'b1;
        end else begin
          st.on = 1'b0;
        end
      end
      default: begin
        if (!st.on) begin
          st.elapsed = 0;
        end else begin
          st.elapsed = (st.elapsed + longint'(c.dms) > TIMER_MAX) ? TIMER_MAX
                                                                  : st.elapsed + c.dms;
          err = st.target - int'($signed(c.rpm));
          mag = (err < 0) ? -err : err;
          // outside the dead band but inside the window that opens with time
          if (50 * mag > st.target &&
              longint'(500 * mag) < longint'(20 * st.target) + st.elapsed) begin
            st.power += (err >= 0) ? int'(POWER_STEP) : -int'(POWER_STEP);
          end
          if (st.power > POWER_FULL) st.power = POWER_FULL;
          else if (st.power < 0) st.power = 0;
        end
      end
    endcase
    r.running = st.on;
    r.power   = st.power[POWER_W-1:0];
    r.target  = st.target[TARGET_W-1:0];
    r.err     = err[ERR_W-1:0];
    return r;
  endfunction

  task automatic push_cmd(input mode_t m, input int rpm, input int dms);
    fw_cmd_t c;
    c.mode  = m;
    c.rpm   = rpm[RPM_W-1:0];
    c.dms   = dms[DMS_W-1:0];
    c.drain = next_drain;
    next_drain = 1'b0;
    cmd_queue.push_back(c);
    void'(flywheel_update(plan_shadow, c));
  endtask

  task automatic ensure_on();
    if (!plan_shadow.on) push_cmd(MODE_TOGGLE, int'($urandom), int'($urandom));
  endtask

  // sender: bursts of beats with random gaps, optional drain before a beat
  always @(posedge clk) begin
    fw_result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = flywheel_update(ctl_shadow, live_cmd);
        expected_results.push_back(r);
        beats_in++;
        if (ctl_shadow.power == POWER_FULL) full_hits++;
        if (ctl_shadow.on && ctl_shadow.power == 0) zero_hits++;
        if (ctl_shadow.on && ctl_shadow.elapsed == TIMER_MAX) sat_hits++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain && expected_results.size() > 0)) begin
          live_cmd = cmd_queue.pop_front();
          in_valid        <= 1'b1;
          in_mode         <= live_cmd.mode;
          in_measured_rpm <= live_cmd.rpm;
          in_delta_ms     <= live_cmd.dms;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result beat and stalls on a rotating pattern
  always @(posedge clk) begin
    fw_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: unexpected result beat: run %0b pwr %0d tgt %0d err %0d",
                     out_running, out_drive_power, out_target_rpm, out_speed_error);
        end else begin
          want = expected_results.pop_front();
          if (out_running !== want.running || out_drive_power !== want.power ||
              out_target_rpm !== want.target || out_speed_error !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tb: beat %0d exp/act run %0b/%0b pwr %0d/%0d tgt %0d/%0d err %0d/%0d",
                       beats_out, want.running, out_running, want.power, out_drive_power,
                       want.target, out_target_rpm, want.err, out_speed_error);
          end
        end
      end
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 8'hFF;
          1: ready_pat = 8'hEE;
          2: ready_pat = 8'h92;
          default: ready_pat = $urandom;
        endcase
        pat_left = 48;
      end else begin
        pat_left--;
      end
      out_ready <= ready_pat[pat_pos];
      pat_pos <= pat_pos + 3'd1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d of %0d beats sent, %0d results",
               cycle_count, beats_in, total_cmds, beats_out);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    // directed: off ticks, field extremes, window edges, toggles
    push_cmd(MODE_TICK, 0, 0);
    push_cmd(MODE_TICK, -1024, 255);
    push_cmd(MODE_RAISE, 1023, 0);
    push_cmd(MODE_LOWER, -1, 255);
    push_cmd(MODE_TOGGLE, 0, 0);
    push_cmd(MODE_TICK, -1024, 255);
    push_cmd(MODE_TICK, 1023, 0);
    push_cmd(MODE_TICK, plan_shadow.target - 12, 0);
    push_cmd(MODE_TICK, plan_shadow.target + 12, 170);
    push_cmd(MODE_TICK, plan_shadow.target - 9, 85);   // inside the dead band
    push_cmd(MODE_TICK, plan_shadow.target, 1);
    push_cmd(MODE_TICK, plan_shadow.target - 20, 255);
    push_cmd(MODE_TOGGLE, 0, 0);                       // off keeps the power
    push_cmd(MODE_TICK, plan_shadow.target - 12, 99);  // off tick clears the timer
    push_cmd(MODE_TOGGLE, 1023, 255);
    push_cmd(MODE_TICK, -1, 255);

    // climb to the upper limit, then push the power into full scale
    next_drain = 1'b1;
    for (k = 0; k < 30; k++) push_cmd(MODE_RAISE, int'($urandom), int'($urandom));
    ensure_on();
    for (k = 0; k < 10; k++)
      push_cmd(MODE_TICK, plan_shadow.target - int'($urandom_range(12, 23)),
               int'($urandom));

    // drop to the lower limit and pull the power down toward zero while the timer saturates
    for (k = 0; k < 52; k++) push_cmd(MODE_LOWER, int'($urandom), int'($urandom));
    ensure_on();
    for (k = 0; k < 330; k++)
      push_cmd(MODE_TICK, plan_shadow.target + int'($urandom_range(7, 13)),
               int'($urandom_range(240, 255)));

    while (cmd_queue.size() < PLAN_ITEMS) begin
      next_drain = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 4))
        0: begin
          n = $urandom_range(1, 12);
          for (k = 0; k < n; k++) push_cmd(MODE_RAISE, int'($urandom), int'($urandom));
        end
        1: begin
          n = $urandom_range(1, 12);
          for (k = 0; k < n; k++) push_cmd(MODE_LOWER, int'($urandom), int'($urandom));
        end
        2: begin
          ensure_on();
          n = $urandom_range(4, 20);
          for (k = 0; k < n; k++)
            push_cmd(MODE_TICK, plan_shadow.target + int'($urandom_range(0, 60)) - 30,
                     int'($urandom));
        end
        3: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++)
            push_cmd(mode_t'($urandom_range(0, 3)), int'($urandom), int'($urandom));
        end
        default: begin
          if (plan_shadow.on) push_cmd(MODE_TOGGLE, int'($urandom), int'($urandom));
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) push_cmd(MODE_TICK, int'($urandom), int'($urandom));
        end
      endcase
    end
    total_cmds = cmd_queue.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in < total_cmds || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_results.size() > 0) begin
      $display("tb: %0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    $display("tb: %0d command beats, %0d result beats, %0d mismatches",
             beats_in, beats_out, mismatches);
    $display("tb: power at full scale on %0d beats, at zero while on %0d, timer pinned %0d",
             full_hits, zero_hits, sat_hits);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> flywheel_speed_stepper.f
design/fss_pkg.sv
design/fss_step.sv
design/flywheel_speed_stepper.sv
tb/tb_flywheel_speed_stepper.sv
